>>> rtl/core/label_filtered_neighbor_aggregate_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the neighbor aggregate core
// Clocked on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef LABEL_FILTERED_NEIGHBOR_AGGREGATE_CORE_MACROS_SVH
`define LABEL_FILTERED_NEIGHBOR_AGGREGATE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS
`define LFNA_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define LFNA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define LFNA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LFNA_ASSERT(lbl, cond, msg)
`define LFNA_ASSERT_IMP(lbl, ante, cons, msg)
`define LFNA_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/core/lfna_pkg.sv
// ----------------------------------------------------------------------------
// lfna_pkg
// Widths, reset values, register indexes and stage payload types.
// ----------------------------------------------------------------------------
package lfna_pkg;

  localparam int VALUE_W    = 16;
  localparam int CLASS_W    = 8;
  localparam int WEIGHT_W   = 16;
  localparam int SUM_W      = 24;
  localparam int PROD_W     = SUM_W + WEIGHT_W;
  localparam int USED_W     = 6;
  localparam int LIMIT_W    = 6;
  localparam int BIAS_W     = 16;
  localparam int NEWVAL_W   = 15;
  localparam int S_TDATA_W  = 48;
  localparam int M_TDATA_W  = 24;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam int LABEL_BITS_DEF = 8;
  localparam int COUNT_BITS_DEF = 6;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(50);
  localparam logic [BIAS_W-1:0]  BIAS_RESET  = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NEIGHBOR_LIMIT = 1'b0,
    REG_LAYER_BIAS     = 1'b1
  } cfg_reg_t;

  // final sum of one target feature, waiting for the multiplier
  typedef struct packed {
    logic signed [SUM_W-1:0]    sum;
    logic        [USED_W-1:0]   count;
    logic signed [WEIGHT_W-1:0] weight;
  } fin_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] prod;
    logic        [USED_W-1:0] count;
  } prod_t;

endpackage

>>> rtl/core/lfna_accum.sv
// ----------------------------------------------------------------------------
// lfna_accum
// Label match, limited saturating running sum, capture of the final sum.
// ----------------------------------------------------------------------------
`include "label_filtered_neighbor_aggregate_core_macros.svh"

module lfna_accum import lfna_pkg::*; #(
  parameter int LABEL_BITS = LABEL_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       acc,
  input  logic signed [VALUE_W-1:0]  neighbor_value,
  input  logic        [CLASS_W-1:0]  neighbor_class,
  input  logic        [CLASS_W-1:0]  target_class,
  input  logic signed [WEIGHT_W-1:0] feature_weight,
  input  logic                       last_neighbor,
  input  logic        [LIMIT_W-1:0]  neighbor_limit,
  input  logic                       fin_take,
  output logic                       fin_valid,
  output fin_t                       fin
);

  localparam int CMP_BITS = (LABEL_BITS < CLASS_W) ? LABEL_BITS : CLASS_W;
  localparam int EXT_W    = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;

  logic signed [SUM_W-1:0]   running_sum;
  logic        [COUNT_BITS-1:0] match_count;

  logic                      match;
  logic                      room;
  logic [SUM_W:0]            sum_wide;
  logic signed [SUM_W-1:0]   sum_next;
  logic [COUNT_BITS-1:0]     count_next;
  logic [EXT_W-1:0]          count_ext;
  logic [EXT_W-1:0]          limit_ext;
  logic [EXT_W-1:0]          count_next_ext;

  assign match     = neighbor_class[CMP_BITS-1:0] == target_class[CMP_BITS-1:0];
  assign count_ext = EXT_W'(match_count);
  assign limit_ext = EXT_W'(neighbor_limit);
  assign room      = (count_ext < limit_ext) && (match_count != '1);

  always_comb begin
    sum_wide   = {running_sum[SUM_W-1], running_sum}
               + {{(SUM_W + 1 - VALUE_W){neighbor_value[VALUE_W-1]}}, neighbor_value};
    sum_next   = running_sum;
    count_next = match_count;
    if (match && room) begin
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
        sum_next = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
        sum_next = sum_wide[SUM_W-1:0];
      end
      count_next = match_count + 1'b1;
    end
  end

  assign count_next_ext = EXT_W'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      match_count <= '0;
      fin_valid   <= 1'b0;
    end else begin
      if (acc) begin
        if (last_neighbor) begin
          running_sum <= '0;
          match_count <= '0;
        end else begin
          running_sum <= sum_next;
          match_count <= count_next;
        end
      end
      if (acc && last_neighbor) begin
        fin_valid <= 1'b1;
      end else if (fin_take) begin
        fin_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && last_neighbor) begin
      fin.sum    <= sum_next;
      fin.count  <= count_next_ext[USED_W-1:0];
      fin.weight <= feature_weight;
    end
  end

  `LFNA_ASSERT_NEXT(a_state_cleared, acc && last_neighbor, running_sum == '0 && match_count == '0, "state not cleared after last neighbor")
  `LFNA_ASSERT_NEXT(a_fin_loaded, acc && last_neighbor, fin_valid, "final sum not captured")
  `LFNA_ASSERT_NEXT(a_count_grows, acc && !last_neighbor, match_count >= $past(match_count), "match count fell mid list")

endmodule

>>> rtl/core/lfna_mul.sv
// ----------------------------------------------------------------------------
// lfna_mul
// Registered product of the final sum and the feature weight.
// ----------------------------------------------------------------------------
module lfna_mul import lfna_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  fin_valid,
  input  fin_t  fin,
  output logic  fin_take,
  input  logic  prod_take,
  output logic  prod_valid,
  output prod_t prod
);

  logic free;

  assign free     = !prod_valid || prod_take;
  assign fin_take = fin_valid && free;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (free) begin
      prod_valid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_take) begin
      prod.prod  <= PROD_W'($signed(fin.sum) * $signed(fin.weight));
      prod.count <= fin.count;
    end
  end

endmodule

>>> rtl/core/lfna_out.sv
// ----------------------------------------------------------------------------
// lfna_out
// Scale back to Q8.8, add bias, ReLU and clip; holds the result request.
// ----------------------------------------------------------------------------
module lfna_out import lfna_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     prod_valid,
  input  prod_t                    prod,
  input  logic signed [BIAS_W-1:0] layer_bias,
  output logic                     prod_take,
  output logic                     res_valid,
  input  logic                     res_ready,
  output logic [NEWVAL_W-1:0]      new_value,
  output logic [USED_W-1:0]        used_count,
  output logic                     saturated
);

  localparam int SHIFT_W = PROD_W - 8;

  logic [SHIFT_W-1:0]  scaled;
  logic [SHIFT_W:0]    total;
  logic [NEWVAL_W-1:0] value_next;
  logic                sat_next;

  // arithmetic shift by 8 rounds toward minus infinity
  assign scaled = prod.prod[PROD_W-1:8];
  assign total  = {scaled[SHIFT_W-1], scaled}
                + {{(SHIFT_W + 1 - BIAS_W){layer_bias[BIAS_W-1]}}, layer_bias};

  always_comb begin
    value_next = '0;
    sat_next   = 1'b0;
    if (!total[SHIFT_W] && total != '0) begin
      if (total[SHIFT_W-1:NEWVAL_W] != '0) begin
        value_next = '1;
        sat_next   = 1'b1;
      end else begin
        value_next = total[NEWVAL_W-1:0];
      end
    end
  end

  assign prod_take = prod_valid && (!res_valid || res_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (!res_valid || res_ready) begin
      res_valid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_take) begin
      new_value  <= value_next;
      used_count <= prod.count;
      saturated  <= sat_next;
    end
  end

endmodule

>>> rtl/core/label_filtered_neighbor_aggregate_core.sv
// ----------------------------------------------------------------------------
// label_filtered_neighbor_aggregate_core
// Label-filtered neighbor sum per target feature, scaled, biased and ReLU'd.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata, s_tlast (last neighbor)
//  m_      | out | m_tvalid/m_tready  | m_tdata, m_tuser (saturated)
//  cfg_    | in  | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One neighbor accepted per cycle while s_tready is high; the running sum
// updates in the cycle of acceptance. The last neighbor loads the final-sum
// register, then the product and result (m_tvalid) registers load in turn.
// Each stage moves when the one after it is empty or being emptied; input
// stalls only while all three stages are full and m_tready is low.
// Synchronous reset clears the running sum, count, stage valids and loads
// the register reset values.
// ----------------------------------------------------------------------------
module label_filtered_neighbor_aggregate_core import lfna_pkg::*; #(
  parameter int LABEL_BITS = LABEL_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // [15:0] neighbor_value, [23:16] neighbor_class, [31:24] target_class,
  // [47:32] feature_weight
  input  logic [S_TDATA_W-1:0]  s_tdata,
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [14:0] new_value, [20:15] used_count, [23:21] zero
  output logic [M_TDATA_W-1:0]  m_tdata,
  // [0] saturated
  output logic                  m_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [LIMIT_W-1:0]       neighbor_limit;
  logic signed [BIAS_W-1:0] layer_bias;

  logic  acc;
  logic  fin_valid;
  logic  fin_take;
  fin_t  fin;
  logic  prod_valid;
  logic  prod_take;
  prod_t prod;

  logic [NEWVAL_W-1:0] new_value;
  logic [USED_W-1:0]   used_count;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      neighbor_limit <= LIMIT_RESET;
      layer_bias     <= BIAS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_NEIGHBOR_LIMIT: neighbor_limit <= cfg_data[LIMIT_W-1:0];
        REG_LAYER_BIAS:     layer_bias     <= cfg_data[BIAS_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_tready = !fin_valid || fin_take;
  assign acc      = s_tvalid && s_tready;

  lfna_accum #(
    .LABEL_BITS (LABEL_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_accum (
    .clk            (clk),
    .rst            (rst),
    .acc            (acc),
    .neighbor_value (s_tdata[15:0]),
    .neighbor_class (s_tdata[23:16]),
    .target_class   (s_tdata[31:24]),
    .feature_weight (s_tdata[47:32]),
    .last_neighbor  (s_tlast),
    .neighbor_limit (neighbor_limit),
    .fin_take       (fin_take),
    .fin_valid      (fin_valid),
    .fin            (fin)
  );

  lfna_mul u_mul (
    .clk        (clk),
    .rst        (rst),
    .fin_valid  (fin_valid),
    .fin        (fin),
    .fin_take   (fin_take),
    .prod_take  (prod_take),
    .prod_valid (prod_valid),
    .prod       (prod)
  );

  lfna_out u_out (
    .clk        (clk),
    .rst        (rst),
    .prod_valid (prod_valid),
    .prod       (prod),
    .layer_bias (layer_bias),
    .prod_take  (prod_take),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .new_value  (new_value),
    .used_count (used_count),
    .saturated  (m_tuser)
  );

  assign m_tdata = {{(M_TDATA_W - NEWVAL_W - USED_W){1'b0}}, used_count, new_value};

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: label-filtered neighbor aggregate core
// Feeds neighbor lists through the slave stream, predicts each target
// feature result (filtered sum, scale, bias, ReLU, clip) in the bench and
// checks every result request on the master stream in order. Covers the
// register extremes, random idling on both sides and a long output stall.
// ----------------------------------------------------------------------------
module tb_top;
  import lfna_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYC   = 8;
  localparam int HOLD_CYC    = 300;
  localparam int COUNT_MAX   = (1 << COUNT_BITS_DEF) - 1;
  localparam int SUM_MAX     = 8388607;
  localparam int SUM_MIN     = -8388608;
  localparam int OUT_MAX     = 32767;

  typedef struct {
    logic signed [VALUE_W-1:0]  value;
    logic        [CLASS_W-1:0]  ncls;
    logic        [CLASS_W-1:0]  tcls;
    logic signed [WEIGHT_W-1:0] weight;
    logic                       last;
  } nbr_t;

  typedef struct {
    logic [NEWVAL_W-1:0] new_value;
    logic [USED_W-1:0]   used;
    logic                sat;
  } agg_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata = '0;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  m_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // bench copy of the block state and registers
  logic        [LIMIT_W-1:0] lim_reg  = LIMIT_RESET;
  logic signed [BIAS_W-1:0]  bias_reg = BIAS_RESET;
  logic signed [SUM_W-1:0]   acc_sum  = '0;
  logic        [USED_W-1:0]  sum_cnt  = '0;

  nbr_t nbr_q[$];
  agg_t aggregate_q[$];
  int   queued_cnt = 0;
  int   taken_cnt  = 0;
  int   err_cnt    = 0;
  int   cyc        = 0;
  int   tx_idle_pct = 26;
  int   rx_idle_pct = 53;
  int   hold_left  = 0;
  logic hold_req   = 1'b0;
  logic hold_seen  = 1'b0;

  label_filtered_neighbor_aggregate_core dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // filtered accumulate; on the last neighbor, produce the expected result
  function automatic void fold_neighbor(nbr_t it);
    int     s;
    longint p;
    longint r;
    agg_t   a;
    if (it.ncls == it.tcls && sum_cnt < lim_reg && sum_cnt < COUNT_MAX) begin
      s = acc_sum + it.value;
      if (s > SUM_MAX) s = SUM_MAX;
      if (s < SUM_MIN) s = SUM_MIN;
      acc_sum = s[SUM_W-1:0];
      sum_cnt = sum_cnt + 1'b1;
    end
    if (it.last) begin
      p = longint'(acc_sum) * longint'(it.weight);
      r = (p >>> 8) + longint'(bias_reg);
      a.sat = 1'b0;
      if (r <= 0) begin
        a.new_value = '0;
      end else if (r > OUT_MAX) begin
        a.new_value = NEWVAL_W'(OUT_MAX);
        a.sat = 1'b1;
      end else begin
        a.new_value = r[NEWVAL_W-1:0];
      end
      a.used = sum_cnt;
      aggregate_q.push_back(a);
      acc_sum = '0;
      sum_cnt = '0;
    end
  endfunction

  task automatic check_field(string fname, int want, int got);
    if (want != got) begin
      $display("%0t %s mismatch: expected %0d actual %0d", $time, fname, want, got);
      err_cnt++;
    end
  endtask

  // driver: next neighbor request once the current one is taken
  always @(posedge clk) begin : drive_proc
    nbr_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (nbr_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        it = nbr_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {it.weight, it.tcls, it.ncls, it.value};
        s_tlast  <= it.last;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random backpressure plus a long hold on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYC;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // monitor: predict on input requests, check output requests
  always @(posedge clk) begin : watch_proc
    nbr_t it;
    agg_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        it.value  = s_tdata[15:0];
        it.ncls   = s_tdata[23:16];
        it.tcls   = s_tdata[31:24];
        it.weight = s_tdata[47:32];
        it.last   = s_tlast;
        taken_cnt++;
        fold_neighbor(it);
      end
      if (m_tvalid && m_tready) begin
        if (aggregate_q.size() == 0) begin
          $display("%0t unexpected result: expected none actual new_value %0d used %0d sat %0d",
                   $time, m_tdata[NEWVAL_W-1:0], m_tdata[NEWVAL_W +: USED_W], m_tuser);
          err_cnt++;
        end else begin
          want = aggregate_q.pop_front();
          check_field("new_value", want.new_value, m_tdata[NEWVAL_W-1:0]);
          check_field("used_count", want.used, m_tdata[NEWVAL_W +: USED_W]);
          check_field("saturated", want.sat, m_tuser);
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > CYCLE_LIMIT) begin
      $display("** label_filtered_neighbor_aggregate_core: FAILED **");
      $finish;
    end
  end

  task automatic queue_nbr(int value, int ncls, int tcls, int weight, bit last);
    nbr_t it;
    it.value  = value[VALUE_W-1:0];
    it.ncls   = ncls[CLASS_W-1:0];
    it.tcls   = tcls[CLASS_W-1:0];
    it.weight = weight[WEIGHT_W-1:0];
    it.last   = last;
    nbr_q.push_back(it);
    queued_cnt++;
  endtask

  function automatic int pick_q88();
    case ($urandom_range(7))
      0: return -32768;
      1: return 32767;
      2: return $urandom_range(3) - 1;
      3: return $urandom_range(512) - 256;
      default: return $urandom_range(65535);
    endcase
  endfunction

  // one target's neighbor list; target label drifts now and then as noise
  task automatic queue_list(int len, int match_pct);
    int tcls;
    int t;
    tcls = $urandom_range(255);
    for (int k = 0; k < len; k++) begin
      t = ($urandom_range(19) == 0) ? $urandom_range(255) : tcls;
      queue_nbr(pick_q88(), ($urandom_range(99) < match_pct) ? t : $urandom_range(255),
                t, pick_q88(), k == len - 1);
    end
  endtask

  task automatic queue_lists(int n_items);
    int made;
    int len;
    made = 0;
    while (made < n_items) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(70, 40) : $urandom_range(8, 1);
      queue_list(len, 65);
      made += len;
    end
  endtask

  // wait until every queued neighbor is taken and every result is back
  task automatic drain();
    while (taken_cnt != queued_cnt || aggregate_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, int data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_NEIGHBOR_LIMIT) lim_reg = data[LIMIT_W-1:0];
    else bias_reg = data[BIAS_W-1:0];
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset registers: clip, negative, label mismatch, mixed list
    queue_nbr(32767, 0, 0, 32767, 1);
    queue_nbr(-32768, 255, 255, 32767, 1);
    queue_nbr(32767, 255, 0, -32768, 1);
    queue_nbr(256, 7, 7, 0, 0);
    queue_nbr(512, 8, 7, 0, 0);
    queue_nbr(-128, 7, 7, 512, 1);
    queue_nbr(32767, 1, 1, -32768, 1);
    queue_nbr(-32768, 1, 1, -32768, 1);
    drain();

    // limit reached and floor rounding of negative products
    write_reg(REG_NEIGHBOR_LIMIT, 2);
    write_reg(REG_LAYER_BIAS, 2);
    queue_nbr(-1, 3, 3, 0, 0);
    queue_nbr(0, 3, 3, 0, 0);
    queue_nbr(5000, 3, 3, 0, 0);
    queue_nbr(5000, 3, 3, 1, 1);
    queue_nbr(-1, 9, 9, 256, 1);
    drain();

    // limit zero: result is the bias alone
    write_reg(REG_NEIGHBOR_LIMIT, 0);
    write_reg(REG_LAYER_BIAS, 32767);
    queue_nbr(32767, 5, 5, 256, 0);
    queue_nbr(32767, 5, 5, 256, 1);
    drain();

    // random: widest limit, count ceiling, lowest bias
    write_reg(REG_NEIGHBOR_LIMIT, 63);
    write_reg(REG_LAYER_BIAS, -32768);
    queue_list(70, 100);
    queue_lists(150);
    drain();

    // swap idling; long output hold so the input stalls
    tx_idle_pct <= 53;
    rx_idle_pct <= 26;
    write_reg(REG_NEIGHBOR_LIMIT, 1);
    write_reg(REG_LAYER_BIAS, 32767);
    queue_lists(150);
    hold_req <= ~hold_req;
    drain();

    // no idling; sender pauses until all results are back midway
    tx_idle_pct <= 0;
    rx_idle_pct <= 0;
    write_reg(REG_NEIGHBOR_LIMIT, $urandom_range(63));
    write_reg(REG_LAYER_BIAS, $urandom_range(65535));
    queue_lists(75);
    drain();
    queue_lists(75);
    drain();

    write_reg(REG_NEIGHBOR_LIMIT, LIMIT_RESET);
    write_reg(REG_LAYER_BIAS, $urandom_range(65535));
    queue_lists(60);
    drain();

    if (err_cnt == 0) begin
      $display("** label_filtered_neighbor_aggregate_core: PASSED **");
    end else begin
      $display("** label_filtered_neighbor_aggregate_core: FAILED **");
    end
    $finish;
  end

endmodule

>>> label_filtered_neighbor_aggregate_core.f
+incdir+rtl/core
rtl/core/lfna_pkg.sv
rtl/core/lfna_accum.sv
rtl/core/lfna_mul.sv
rtl/core/lfna_out.sv
rtl/core/label_filtered_neighbor_aggregate_core.sv
dv/tb_top.sv
